// ----- design/assert_macros.svh -----
// assertion helpers included by ycrf_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, pre, post, msg) \
	`ASSERT_CLK(lbl, (pre) |-> (post), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post, msg) \
	`ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

// ----- design/ycrf_pkg.sv -----
package ycrf_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int TOP_ROWS_DEF  = 25;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int WIDTH_W  = 11;
	localparam int TOTAL_W  = 20;
	localparam int LEFT_W   = 10;
	localparam int RIGHT_W  = 14;
	localparam int POS_W    = 13;
	localparam int LEFT_COLS = 32;

	localparam logic [7:0] U_MATCH = 8'd64;
	localparam logic [7:0] V_MATCH = 8'd255;
	localparam logic [7:0] C_GRAY  = 8'd127;

	typedef enum logic [2:0] {
		REG_LUMA_MIN  = 3'd0,
		REG_LUMA_MAX  = 3'd1,
		REG_BLUE_MIN  = 3'd2,
		REG_BLUE_MAX  = 3'd3,
		REG_RED_MIN   = 3'd4,
		REG_RED_MAX   = 3'd5,
		REG_WIDTH     = 3'd6,
		REG_PAINT     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] u_in;
		logic [7:0] y0_in;
		logic [7:0] v_in;
		logic [7:0] y1_in;
		logic       frame_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         u_out;
		logic [7:0]         y0_out;
		logic [7:0]         v_out;
		logic [7:0]         y1_out;
		logic               is_match;
		logic [TOTAL_W-1:0] match_total;
		logic [LEFT_W-1:0]  left_top_count;
		logic [RIGHT_W-1:0] right_top_count;
		logic               frame_done;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]         luma_min;
		logic [7:0]         luma_max;
		logic [7:0]         blue_diff_min;
		logic [7:0]         blue_diff_max;
		logic [7:0]         red_diff_min;
		logic [7:0]         red_diff_max;
		logic [WIDTH_W-1:0] width_pixels;
		logic               paint_enable;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		luma_min:      8'd0,
		luma_max:      8'd255,
		blue_diff_min: 8'd0,
		blue_diff_max: 8'd255,
		red_diff_min:  8'd0,
		red_diff_max:  8'd255,
		width_pixels:  11'd128,
		paint_enable:  1'b1
	};

endpackage

// ----- design/ycrf_cfg.sv -----
module ycrf_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ycrf_pkg::ADDR_W-1:0]  paddr,
	input  logic [ycrf_pkg::DATA_W-1:0]  pwdata,
	output logic [ycrf_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output ycrf_pkg::cfg_t               cfg
);

	ycrf_pkg::cfg_t   cfg_q;
	ycrf_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = ycrf_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ycrf_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				ycrf_pkg::REG_LUMA_MIN: cfg_q.luma_min      <= pwdata[7:0];
				ycrf_pkg::REG_LUMA_MAX: cfg_q.luma_max      <= pwdata[7:0];
				ycrf_pkg::REG_BLUE_MIN: cfg_q.blue_diff_min <= pwdata[7:0];
				ycrf_pkg::REG_BLUE_MAX: cfg_q.blue_diff_max <= pwdata[7:0];
				ycrf_pkg::REG_RED_MIN:  cfg_q.red_diff_min  <= pwdata[7:0];
				ycrf_pkg::REG_RED_MAX:  cfg_q.red_diff_max  <= pwdata[7:0];
				ycrf_pkg::REG_WIDTH:    cfg_q.width_pixels  <= pwdata[ycrf_pkg::WIDTH_W-1:0];
				ycrf_pkg::REG_PAINT:    cfg_q.paint_enable  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			ycrf_pkg::REG_LUMA_MIN: prdata[7:0] = cfg_q.luma_min;
			ycrf_pkg::REG_LUMA_MAX: prdata[7:0] = cfg_q.luma_max;
			ycrf_pkg::REG_BLUE_MIN: prdata[7:0] = cfg_q.blue_diff_min;
			ycrf_pkg::REG_BLUE_MAX: prdata[7:0] = cfg_q.blue_diff_max;
			ycrf_pkg::REG_RED_MIN:  prdata[7:0] = cfg_q.red_diff_min;
			ycrf_pkg::REG_RED_MAX:  prdata[7:0] = cfg_q.red_diff_max;
			ycrf_pkg::REG_WIDTH:    prdata[ycrf_pkg::WIDTH_W-1:0] = cfg_q.width_pixels;
			ycrf_pkg::REG_PAINT:    prdata[0] = cfg_q.paint_enable;
			default: ;
		endcase
	end

endmodule

// ----- design/ycrf_match.sv -----
module ycrf_match (
	input  ycrf_pkg::cfg_t     cfg,
	input  ycrf_pkg::in_beat_t beat,
	output logic               match,
	output logic [7:0]         u_paint,
	output logic [7:0]         v_paint
);

	logic y_ok, u_ok, v_ok;

	// inclusive window tests, an empty window never passes
	assign y_ok = (beat.y0_in >= cfg.luma_min) && (beat.y0_in <= cfg.luma_max);
	assign u_ok = (beat.u_in >= cfg.blue_diff_min) && (beat.u_in <= cfg.blue_diff_max);
	assign v_ok = (beat.v_in >= cfg.red_diff_min) && (beat.v_in <= cfg.red_diff_max);
	assign match = y_ok && u_ok && v_ok;

	always_comb begin
		u_paint = beat.u_in;
		v_paint = beat.v_in;
		if (cfg.paint_enable) begin
			u_paint = match ? ycrf_pkg::U_MATCH : ycrf_pkg::C_GRAY;
			v_paint = match ? ycrf_pkg::V_MATCH : ycrf_pkg::C_GRAY;
		end
	end

endmodule

// ----- design/ycrf_core.sv -----
`include "assert_macros.svh"

module ycrf_core #(
	parameter int MAX_WIDTH = ycrf_pkg::MAX_WIDTH_DEF,
	parameter int TOP_ROWS  = ycrf_pkg::TOP_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ycrf_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  ycrf_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ycrf_pkg::out_beat_t out_data
);

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;
	localparam int ROW_W = (TOP_ROWS > 0) ? $clog2(TOP_ROWS + 1) : 1;
	localparam int PW    = ycrf_pkg::POS_W;
	localparam int TW    = ycrf_pkg::TOTAL_W;
	localparam int LW    = ycrf_pkg::LEFT_W;
	localparam int RW    = ycrf_pkg::RIGHT_W;

	logic                vld_s1;
	ycrf_pkg::in_beat_t  beat_s1;
	logic                vld_s2;
	ycrf_pkg::out_beat_t beat_s2;
	logic                adv;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [TW-1:0]    tot_q;
	logic [LW-1:0]    left_q;
	logic [RW-1:0]    right_q;

	logic             match;
	logic [7:0]       u_paint, v_paint;
	logic             in_top, in_left;
	logic [TW-1:0]    tot_nxt;
	logic [LW-1:0]    left_nxt;
	logic [RW-1:0]    right_nxt;
	logic [PW-1:0]    w_clamp, mpr, col_inc;
	logic             wrap;
	logic [RW:0]      top_sum;

	ycrf_match u_match (
		.cfg     (cfg),
		.beat    (beat_s1),
		.match   (match),
		.u_paint (u_paint),
		.v_paint (v_paint)
	);

	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;
	assign out_valid = vld_s2;
	assign out_data  = beat_s2;

	// region of the current macropixel
	assign in_top  = row_q < ROW_W'(TOP_ROWS);
	assign in_left = PW'(col_q) < PW'(ycrf_pkg::LEFT_COLS);

	// saturating counter updates
	always_comb begin
		tot_nxt   = tot_q;
		left_nxt  = left_q;
		right_nxt = right_q;
		if (match) begin
			if (!(&tot_q)) tot_nxt = tot_q + TW'(1);
			if (in_top && in_left && !(&left_q)) left_nxt = left_q + LW'(1);
			if (in_top && !in_left && !(&right_q)) right_nxt = right_q + RW'(1);
		end
	end

	// row length in macropixels, clamped, at least one
	always_comb begin
		w_clamp = PW'(cfg.width_pixels);
		if (w_clamp > PW'(MAX_WIDTH)) w_clamp = PW'(MAX_WIDTH);
		mpr = w_clamp >> 1;
		if (mpr == '0) mpr = PW'(1);
	end

	assign col_inc = PW'(col_q) + PW'(1);
	assign wrap    = col_inc >= mpr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) beat_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s2.u_out           <= u_paint;
			beat_s2.y0_out          <= beat_s1.y0_in;
			beat_s2.v_out           <= v_paint;
			beat_s2.y1_out          <= beat_s1.y1_in;
			beat_s2.is_match        <= match;
			beat_s2.match_total     <= tot_nxt;
			beat_s2.left_top_count  <= left_nxt;
			beat_s2.right_top_count <= right_nxt;
			beat_s2.frame_done      <= beat_s1.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			tot_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else if (adv) begin
			if (beat_s1.frame_last) begin
				col_q   <= '0;
				row_q   <= '0;
				tot_q   <= '0;
				left_q  <= '0;
				right_q <= '0;
			end else begin
				tot_q   <= tot_nxt;
				left_q  <= left_nxt;
				right_q <= right_nxt;
				if (wrap) begin
					col_q <= '0;
					if (in_top) row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

	assign top_sum = (RW+1)'(left_q) + (RW+1)'(right_q);

	`ASSERT_NEXT(a_frame_clear, adv && beat_s1.frame_last,
		tot_q == '0 && left_q == '0 && right_q == '0 && col_q == '0 && row_q == '0,
		"counters not cleared after frame end")
	`ASSERT_NEXT(a_miss_holds, adv && !beat_s1.frame_last && !match,
		$stable(tot_q) && $stable(left_q) && $stable(right_q),
		"counter moved on a miss")
	`ASSERT_CLK(a_region_bound, TW'(top_sum) <= tot_q,
		"region counts exceed total")

endmodule

// ----- design/yuv_color_range_filter_counter.sv -----
// an accepted beat is registered in beat_s1, then in beat_s2, which drives out_data
// throughput: one macropixel per cycle, limited only by out_ready back pressure
// in_ready drops only while both registers hold a beat and out_ready is low
// reset: arst_n clears valid flags, position and match counters at once
// registers return to their defaults, full range windows, 128 pixel width, painting on
module yuv_color_range_filter_counter #(
	parameter int MAX_WIDTH = ycrf_pkg::MAX_WIDTH_DEF,
	parameter int TOP_ROWS  = ycrf_pkg::TOP_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel stream in
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ycrf_pkg::in_beat_t           in_data,
	// painted pixels and running counts out
	output logic                         out_valid,
	input  logic                         out_ready,
	output ycrf_pkg::out_beat_t          out_data,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ycrf_pkg::ADDR_W-1:0]  paddr,
	input  logic [ycrf_pkg::DATA_W-1:0]  pwdata,
	output logic [ycrf_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	// live register values, user changes only while the stream is idle, not enforced
	ycrf_pkg::cfg_t cfg;

	ycrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// compare, paint and count in one pass between the two registers
	ycrf_core #(
		.MAX_WIDTH (MAX_WIDTH),
		.TOP_ROWS  (TOP_ROWS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
